@@ rtl/core/twdse_pkg.sv @@
// Package for the two-wire display symbol encoder.
// Holds the symbol and timing types, symbol index codes and the symbol pattern function.
// Depends on nothing.
`default_nettype none

package twdse_pkg;

   localparam int QuarterWidth = 14;
   localparam int TimeWidth    = 15;
   localparam int IndexWidth   = 4;

   localparam logic [QuarterWidth-1:0] QuarterReset = 14'd200;
   localparam logic [TimeWidth-1:0]    TimeMax      = 15'h7FFF;

   localparam logic [IndexWidth-1:0] SymLead  = 4'd0;
   localparam logic [IndexWidth-1:0] SymAck1  = 4'd9;
   localparam logic [IndexWidth-1:0] SymAck2  = 4'd10;
   localparam logic [IndexWidth-1:0] SymTail  = 4'd11;

   typedef enum logic [1:0] {
      QuarterOne   = 2'd1,
      QuarterTwo   = 2'd2,
      QuarterThree = 2'd3
   } quarters_type;

   typedef struct packed {
      logic         clk_level_a;
      quarters_type clk_quarters_a;
      logic         clk_level_b;
      quarters_type clk_quarters_b;
      logic         dio_level_a;
      quarters_type dio_quarters_a;
      logic         dio_level_b;
      quarters_type dio_quarters_b;
      logic         end_of_byte;
      logic         end_of_transfer;
   } symbol_type;

   typedef struct packed {
      logic       valid;
      symbol_type symbol;
   } symbol_out_type;

   typedef struct packed {
      logic [TimeWidth-1:0] one;
      logic [TimeWidth-1:0] two;
      logic [TimeWidth-1:0] three;
   } quarter_times_type;

   function automatic symbol_type symbol_pattern(
      input logic [IndexWidth-1:0] index,
      input logic [7:0]            data_byte,
      input logic                  first_byte,
      input logic                  last_byte
   );
      symbol_type sym;
      logic [IndexWidth-1:0] bit_pos;
      logic b;
      bit_pos = index - 4'd1;
      b = data_byte[bit_pos[2:0]];
      sym = '{1'b1, QuarterOne, 1'b1, QuarterOne,
              1'b0, QuarterOne, 1'b0, QuarterOne, 1'b0, 1'b0};
      case (index)
         SymLead: begin
            if (first_byte) begin
               sym.dio_quarters_a = QuarterTwo;
            end
         end
         SymAck1: begin
            sym.clk_level_b    = 1'b0;
            sym.clk_quarters_b = QuarterTwo;
            sym.dio_quarters_b = QuarterTwo;
         end
         SymAck2: begin
         end
         SymTail: begin
            sym.end_of_byte = 1'b1;
            if (last_byte) begin
               sym = '{1'b0, QuarterTwo, 1'b1, QuarterThree,
                       1'b0, QuarterTwo, 1'b1, QuarterTwo, 1'b1, 1'b1};
            end
         end
         default: begin
            sym = '{1'b0, QuarterTwo, 1'b1, QuarterTwo,
                    b, QuarterTwo, b, QuarterTwo, 1'b0, 1'b0};
         end
      endcase
      return sym;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/twdse_timing.sv @@
// Quarter length register and the one, two and three quarter half durations.
// Depends on twdse_pkg.
`default_nettype none

module twdse_timing (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_wr_en,
   input  wire logic [twdse_pkg::QuarterWidth-1:0]    csr_wr_data,
   output twdse_pkg::quarter_times_type               times
);
   import twdse_pkg::*;

   logic [QuarterWidth-1:0] quarter_ff;
   logic [QuarterWidth-1:0] quarter_in;
   logic [TimeWidth-1:0]    one;
   logic [TimeWidth:0]      three_sum;

   always_comb begin
      quarter_in = csr_wr_en ? csr_wr_data : quarter_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quarter_ff <= QuarterReset;
      end else begin
         quarter_ff <= quarter_in;
      end
   end

   // A zero quarter is treated as one tick so that no half lasts zero ticks.
   always_comb begin
      one = (quarter_ff == '0) ? TimeWidth'(1) : TimeWidth'(quarter_ff);
      three_sum = {1'b0, one[TimeWidth-2:0], 1'b0} + {1'b0, one};
      times.one = one;
      times.two = {one[TimeWidth-2:0], 1'b0};
      times.three = (three_sum > {1'b0, TimeMax}) ? TimeMax : three_sum[TimeWidth-1:0];
   end

endmodule

`default_nettype wire

@@ rtl/core/twdse_sequencer.sv @@
// Input register and symbol counter that steps one byte through its twelve symbols.
// Depends on twdse_pkg.
`default_nettype none

module twdse_sequencer (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [7:0]            req_data_byte,
   input  wire logic                  req_first_byte,
   input  wire logic                  req_last_byte,
   input  wire logic                  sym_take,
   output twdse_pkg::symbol_out_type  sym_out
);
   import twdse_pkg::*;

   logic                  busy_ff, busy_in;
   logic [IndexWidth-1:0] index_ff, index_in;
   logic [7:0]            byte_ff, byte_in;
   logic                  first_ff, first_in;
   logic                  last_ff, last_in;
   logic                  advance;
   logic                  finishing;
   logic                  accept;

   always_comb begin
      advance   = busy_ff && sym_take;
      finishing = advance && (index_ff == SymTail);
      req_stall = busy_ff && !finishing;
      accept    = req_valid && !req_stall;

      busy_in  = busy_ff;
      index_in = index_ff;
      byte_in  = byte_ff;
      first_in = first_ff;
      last_in  = last_ff;
      if (advance) begin
         index_in = index_ff + 4'd1;
      end
      if (finishing) begin
         busy_in = 1'b0;
      end
      if (accept) begin
         busy_in  = 1'b1;
         index_in = SymLead;
         byte_in  = req_data_byte;
         first_in = req_first_byte;
         last_in  = req_last_byte;
      end

      sym_out.valid  = busy_ff;
      sym_out.symbol = symbol_pattern(index_ff, byte_ff, first_ff, last_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         index_ff <= SymLead;
      end else begin
         busy_ff  <= busy_in;
         index_ff <= index_in;
      end
      byte_ff  <= byte_in;
      first_ff <= first_in;
      last_ff  <= last_in;
   end

endmodule

`default_nettype wire

@@ rtl/core/two_wire_display_symbol_encoder_unit.sv @@
// Top level of the two-wire display symbol encoder: sequencer, timing and result register.
// Depends on twdse_pkg, twdse_timing and twdse_sequencer.
//
// Each accepted byte produces twelve symbol transfers on the rsp_ channel, one per cycle
// while the output is not stalled, and a new byte is taken in the cycle its last symbol
// is produced. The symbol counter in the sequencer sets this rate. The first symbol of a
// byte passes through the sequencer's input register and the result register before it
// appears on the rsp_ ports. Write csr_wr_data only while no byte is in flight; a quarter
// of zero counts as one tick and durations saturate at 32767.
`default_nettype none

module two_wire_display_symbol_encoder_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_wr_en,
   input  wire logic [twdse_pkg::QuarterWidth-1:0]  csr_wr_data,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [7:0]                          req_data_byte,
   input  wire logic                                req_first_byte,
   input  wire logic                                req_last_byte,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic                                     rsp_clk_level_a,
   output logic [twdse_pkg::TimeWidth-1:0]          rsp_clk_time_a,
   output logic                                     rsp_clk_level_b,
   output logic [twdse_pkg::TimeWidth-1:0]          rsp_clk_time_b,
   output logic                                     rsp_dio_level_a,
   output logic [twdse_pkg::TimeWidth-1:0]          rsp_dio_time_a,
   output logic                                     rsp_dio_level_b,
   output logic [twdse_pkg::TimeWidth-1:0]          rsp_dio_time_b,
   output logic                                     rsp_end_of_byte,
   output logic                                     rsp_end_of_transfer
);
   import twdse_pkg::*;

   quarter_times_type times;
   symbol_out_type    sym_out;
   logic              sym_take;
   logic              valid_ff, valid_in;
   symbol_type        sym;

   logic                 clk_level_a_ff, clk_level_b_ff, dio_level_a_ff, dio_level_b_ff;
   logic [TimeWidth-1:0] clk_time_a_ff, clk_time_b_ff, dio_time_a_ff, dio_time_b_ff;
   logic                 eob_ff, eot_ff;
   logic                 clk_level_a_in, clk_level_b_in, dio_level_a_in, dio_level_b_in;
   logic [TimeWidth-1:0] clk_time_a_in, clk_time_b_in, dio_time_a_in, dio_time_b_in;
   logic                 eob_in, eot_in;

   function automatic logic [TimeWidth-1:0] half_time(
      input quarters_type      quarters,
      input quarter_times_type t
   );
      logic [TimeWidth-1:0] result;
      case (quarters)
         QuarterOne:   result = t.one;
         QuarterTwo:   result = t.two;
         QuarterThree: result = t.three;
         default:      result = t.one;
      endcase
      return result;
   endfunction

   twdse_timing u_timing (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .times       (times)
   );

   twdse_sequencer u_sequencer (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .req_first_byte (req_first_byte),
      .req_last_byte  (req_last_byte),
      .sym_take       (sym_take),
      .sym_out        (sym_out)
   );

   always_comb begin
      sym      = sym_out.symbol;
      sym_take = !valid_ff || !rsp_stall;
      valid_in = sym_take ? sym_out.valid : valid_ff;

      clk_level_a_in = clk_level_a_ff;
      clk_time_a_in  = clk_time_a_ff;
      clk_level_b_in = clk_level_b_ff;
      clk_time_b_in  = clk_time_b_ff;
      dio_level_a_in = dio_level_a_ff;
      dio_time_a_in  = dio_time_a_ff;
      dio_level_b_in = dio_level_b_ff;
      dio_time_b_in  = dio_time_b_ff;
      eob_in         = eob_ff;
      eot_in         = eot_ff;
      if (sym_take && sym_out.valid) begin
         clk_level_a_in = sym.clk_level_a;
         clk_time_a_in  = half_time(sym.clk_quarters_a, times);
         clk_level_b_in = sym.clk_level_b;
         clk_time_b_in  = half_time(sym.clk_quarters_b, times);
         dio_level_a_in = sym.dio_level_a;
         dio_time_a_in  = half_time(sym.dio_quarters_a, times);
         dio_level_b_in = sym.dio_level_b;
         dio_time_b_in  = half_time(sym.dio_quarters_b, times);
         eob_in         = sym.end_of_byte;
         eot_in         = sym.end_of_transfer;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      clk_level_a_ff <= clk_level_a_in;
      clk_time_a_ff  <= clk_time_a_in;
      clk_level_b_ff <= clk_level_b_in;
      clk_time_b_ff  <= clk_time_b_in;
      dio_level_a_ff <= dio_level_a_in;
      dio_time_a_ff  <= dio_time_a_in;
      dio_level_b_ff <= dio_level_b_in;
      dio_time_b_ff  <= dio_time_b_in;
      eob_ff         <= eob_in;
      eot_ff         <= eot_in;
   end

   assign rsp_valid           = valid_ff;
   assign rsp_clk_level_a     = clk_level_a_ff;
   assign rsp_clk_time_a      = clk_time_a_ff;
   assign rsp_clk_level_b     = clk_level_b_ff;
   assign rsp_clk_time_b      = clk_time_b_ff;
   assign rsp_dio_level_a     = dio_level_a_ff;
   assign rsp_dio_time_a      = dio_time_a_ff;
   assign rsp_dio_level_b     = dio_level_b_ff;
   assign rsp_dio_time_b      = dio_time_b_ff;
   assign rsp_end_of_byte     = eob_ff;
   assign rsp_end_of_transfer = eot_ff;

endmodule

`default_nettype wire
